// ===== design/dtit_pkg.sv =====
package dtit_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = 3;
    localparam int MANT_W    = WORD_W * NUM_WORDS;
    localparam int SCALE_W   = 5;
    localparam int DIGIT_W   = 4;
    localparam int PROD_W    = 2 * WORD_W;

    // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x
    localparam logic [WORD_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                RECIP_SHIFT = 35;

    localparam logic [WORD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic [WORD_W-1:0]  mantissa_high;
        logic [WORD_W-1:0]  mantissa_mid;
        logic [WORD_W-1:0]  mantissa_low;
        logic [SCALE_W-1:0] scale;
        logic               negative;
    } in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     overflow;
    } out_t;

endpackage

// ===== design/decimal_to_int_truncate.sv =====
// Channel | Handshake          | Payload           | Direction
// in      | in_valid/in_stall  | in_data  (in_t)   | into block
// out     | out_valid/out_stall| out_data (out_t)  | out of block
//
// An item is divided by ten scale times between acceptance and result:
// each division by ten runs one 32-bit word per cycle through a single
// 32x32 reciprocal multiplier, high word first.
// in_stall is high from acceptance until the result is loaded into the
// output register; the output register holds while out_stall is high.
// Reset clears the sequencer, out_valid and the data registers.
module decimal_to_int_truncate (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  dtit_pkg::in_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output dtit_pkg::out_t out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } state_t;

    state_t                              state_reg;
    logic [dtit_pkg::MANT_W-1:0]         mant_reg;
    logic [dtit_pkg::DIGIT_W-1:0]        rem_reg;
    logic [dtit_pkg::SCALE_W-1:0]        div_cnt_reg;
    logic [1:0]                          word_cnt_reg;
    logic                                neg_reg;
    logic                                out_valid_reg;
    dtit_pkg::out_t                      out_reg;

    logic [dtit_pkg::WORD_W-1:0]         word;
    logic [dtit_pkg::PROD_W-1:0]         prod;
    logic [dtit_pkg::WORD_W-1:0]         wq;
    logic [dtit_pkg::WORD_W-1:0]         wr_full;
    logic [dtit_pkg::DIGIT_W:0]          r_sum;
    logic [dtit_pkg::WORD_W-1:0]         q_sum;
    logic [dtit_pkg::WORD_W-1:0]         q_next;
    logic [dtit_pkg::DIGIT_W-1:0]        r_next;
    logic [dtit_pkg::WORD_W-1:0]         carry_q;
    logic [dtit_pkg::DIGIT_W-1:0]        carry_r;
    logic                                out_free;
    logic                                in_take;
    dtit_pkg::out_t                      result;

    // floor(rem * 2^32 / 10) and its remainder, rem in 0..9
    function automatic logic [dtit_pkg::WORD_W+dtit_pkg::DIGIT_W-1:0] carry_div(
        input logic [dtit_pkg::DIGIT_W-1:0] rem
    );
        logic [dtit_pkg::WORD_W+dtit_pkg::DIGIT_W-1:0] res;
        unique case (rem)
            4'd1:    res = {32'd429496729,  4'd6};
            4'd2:    res = {32'd858993459,  4'd2};
            4'd3:    res = {32'd1288490188, 4'd8};
            4'd4:    res = {32'd1717986918, 4'd4};
            4'd5:    res = {32'd2147483648, 4'd0};
            4'd6:    res = {32'd2576980377, 4'd6};
            4'd7:    res = {32'd3006477107, 4'd2};
            4'd8:    res = {32'd3435973836, 4'd8};
            4'd9:    res = {32'd3865470566, 4'd4};
            default: res = '0;
        endcase
        return res;
    endfunction

    always_comb
    begin
        word    = mant_reg[dtit_pkg::MANT_W-1 -: dtit_pkg::WORD_W];
        prod    = dtit_pkg::PROD_W'(word) * dtit_pkg::PROD_W'(dtit_pkg::RECIP_TEN);
        wq      = dtit_pkg::WORD_W'(prod >> dtit_pkg::RECIP_SHIFT);
        wr_full = word - (wq << 3) - (wq << 1);
        {carry_q, carry_r} = carry_div(rem_reg);
        r_sum   = {1'b0, carry_r} + {1'b0, wr_full[dtit_pkg::DIGIT_W-1:0]};
        q_sum   = carry_q + wq;
        if (r_sum >= 5'd10)
        begin
            q_next = q_sum + 32'd1;
            r_next = dtit_pkg::DIGIT_W'(r_sum - 5'd10);
        end
        else
        begin
            q_next = q_sum;
            r_next = r_sum[dtit_pkg::DIGIT_W-1:0];
        end
    end

    always_comb
    begin
        result = '0;
        if (mant_reg[dtit_pkg::MANT_W-1:dtit_pkg::WORD_W] != '0)
        begin
            result.overflow = 1'b1;
        end
        else if (neg_reg)
        begin
            if (mant_reg[dtit_pkg::WORD_W-1:0] > dtit_pkg::NEG_LIMIT)
                result.overflow = 1'b1;
            else
                result.value = $signed(32'd0 - mant_reg[dtit_pkg::WORD_W-1:0]);
        end
        else
        begin
            if (mant_reg[dtit_pkg::WORD_W-1:0] > dtit_pkg::POS_LIMIT)
                result.overflow = 1'b1;
            else
                result.value = $signed(mant_reg[dtit_pkg::WORD_W-1:0]);
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
            word_cnt_reg  <= '0;
            mant_reg      <= '0;
            rem_reg       <= '0;
            neg_reg       <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_FIN)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        mant_reg     <= {in_data.mantissa_high, in_data.mantissa_mid,
                                         in_data.mantissa_low};
                        neg_reg      <= in_data.negative;
                        div_cnt_reg  <= in_data.scale;
                        word_cnt_reg <= '0;
                        rem_reg      <= '0;
                        state_reg    <= (in_data.scale == '0) ? S_FIN : S_DIV;
                    end
                end
                S_DIV:
                begin
                    // rotate: quotient word enters at the bottom
                    mant_reg <= {mant_reg[dtit_pkg::MANT_W-dtit_pkg::WORD_W-1:0], q_next};
                    if (word_cnt_reg == 2'd2)
                    begin
                        word_cnt_reg <= '0;
                        rem_reg      <= '0;
                        div_cnt_reg  <= div_cnt_reg - 5'd1;
                        if (div_cnt_reg == 5'd1)
                            state_reg <= S_FIN;
                    end
                    else
                    begin
                        word_cnt_reg <= word_cnt_reg + 2'd1;
                        rem_reg      <= r_next;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_reg       <= result;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_cnt_reg != '0)
        else $error("division sequencer running with zero count");

    a_word_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> word_cnt_reg != 2'd3)
        else $error("word counter out of range");

    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |-> out_data.value == '0)
        else $error("overflow result carries a non-zero value");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("input not held off after an item was taken");

endmodule
